// File: hw/rtl/clt_pkg.sv
// Shared types and constants for the compacting list table.
// Beat layouts for both stream sides, operation and status codes.
// No dependencies.
package clt_pkg;

  // Field widths fixed by the interface
  localparam int unsigned OP_W     = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned IN_W     = 72;
  localparam int unsigned OUT_W    = 80;
  localparam int unsigned PAD_W    = OUT_W - COUNT_W - WORD_W - STATUS_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Input beat, first field in the low bits
  typedef struct packed {
    logic [WORD_W-1:0]  value;
    logic [INDEX_W-1:0] index;
    logic [OP_W-1:0]    op;
  } in_beat_t;

  // Output beat, first field in the low bits, zero padded to whole bytes
  typedef struct packed {
    logic [PAD_W-1:0]   pad;
    logic [COUNT_W-1:0] entry_count;
    logic [WORD_W-1:0]  read_value;
    status_t            status;
  } out_beat_t;

endpackage

// File: hw/rtl/clt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module clt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/compacting_list_table_core.sv
// Compacting list table: ordered list of 64-bit words in one RAM plus a count.
// Depends on clt_pkg and clt_ram.
//
//   channel | dir | beat contents (low bit first)
//   --------+-----+-------------------------------------------------------
//   s_axis  | in  | op[1:0], index[7:2], value[71:8]
//   m_axis  | out | status[1:0], read_value[65:2], entry_count[72:66], 0 pad
//
// Append, failed and unknown ops go from accept through S_OUT to the result;
// get passes S_READ first (one RAM read); a delete with words above the index
// passes S_SHIFT, one word moved down per cycle through the single RAM read port.
// Reset clears the count but no RAM word; words are written by append before any read.
// A result not taken waits in the output register while the next beat is
// accepted; a second finished result waits until that register drains.
module compacting_list_table_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [clt_pkg::IN_W-1:0] s_tdata,   // op, index, value
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [clt_pkg::OUT_W-1:0] m_tdata   // status, read_value, entry_count, pad
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W  = clt_pkg::INDEX_W;
  localparam int unsigned CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned OCNT_W = clt_pkg::COUNT_W;
  localparam int unsigned WORD_W = clt_pkg::WORD_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_OUT
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   sh_addr;
  clt_pkg::status_t    res_status;
  logic [WORD_W-1:0]   res_value;
  clt_pkg::out_beat_t  out_beat;

  clt_pkg::in_beat_t   in_beat;
  logic                accept;
  logic [CMP_W-1:0]    idx_ext;
  logic [CMP_W-1:0]    idx_next;
  logic                in_range;
  logic                del_more;
  logic                full;
  logic                sh_more;
  logic [ADDR_W-1:0]   idx_addr;

  logic                ram_wr_en;
  logic [ADDR_W-1:0]   ram_wr_addr;
  logic [WORD_W-1:0]   ram_wr_data;
  logic                ram_rd_en;
  logic [ADDR_W-1:0]   ram_rd_addr;
  logic [WORD_W-1:0]   ram_rd_data;

  // input decode and bounds checks
  assign in_beat  = s_tdata;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign idx_ext  = CMP_W'(in_beat.index);
  assign idx_next = idx_ext + CMP_W'(1);
  assign in_range = idx_ext < CMP_W'(count);
  assign del_more = idx_next < CMP_W'(count);
  assign full     = (count == CAP_C);
  assign idx_addr = idx_ext[ADDR_W-1:0];
  assign sh_more  = (CNT_W'(sh_addr) + CNT_W'(1)) < count;

  // RAM port control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = count[ADDR_W-1:0];
    ram_wr_data = in_beat.value;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_addr;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_beat.op)
            clt_pkg::OP_APPEND: begin
              ram_wr_en = !full;
            end
            clt_pkg::OP_DELETE: begin
              ram_rd_en   = in_range && del_more;
              ram_rd_addr = idx_next[ADDR_W-1:0];
            end
            clt_pkg::OP_GET: begin
              ram_rd_en = in_range;
            end
            default: begin
              ram_rd_en = 1'b0;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // word read last cycle moves down one place
        ram_wr_en   = 1'b1;
        ram_wr_addr = sh_addr - ADDR_W'(1);
        ram_wr_data = ram_rd_data;
        ram_rd_en   = sh_more;
        ram_rd_addr = sh_addr + ADDR_W'(1);
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  clt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // sequencer, count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_value <= '0;
            case (in_beat.op)
              clt_pkg::OP_APPEND: begin
                if (full) begin
                  res_status <= clt_pkg::ST_FULL;
                end else begin
                  res_status <= clt_pkg::ST_DONE;
                  count      <= count + CNT_W'(1);
                end
                state <= S_OUT;
              end
              clt_pkg::OP_DELETE: begin
                if (!in_range) begin
                  res_status <= clt_pkg::ST_RANGE;
                  state      <= S_OUT;
                end else if (del_more) begin
                  sh_addr <= idx_next[ADDR_W-1:0];
                  state   <= S_SHIFT;
                end else begin
                  // last entry removed, nothing to move
                  res_status <= clt_pkg::ST_DONE;
                  count      <= count - CNT_W'(1);
                  state      <= S_OUT;
                end
              end
              clt_pkg::OP_GET: begin
                if (in_range) begin
                  state <= S_READ;
                end else begin
                  res_status <= clt_pkg::ST_RANGE;
                  state      <= S_OUT;
                end
              end
              default: begin
                res_status <= clt_pkg::ST_RANGE;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_READ: begin
          res_status <= clt_pkg::ST_DONE;
          res_value  <= ram_rd_data;
          state      <= S_OUT;
        end
        S_SHIFT: begin
          if (sh_more) begin
            sh_addr <= sh_addr + ADDR_W'(1);
          end else begin
            res_status <= clt_pkg::ST_DONE;
            res_value  <= '0;
            count      <= count - CNT_W'(1);
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_beat.pad         <= '0;
            out_beat.entry_count <= OCNT_W'(count);
            out_beat.read_value  <= res_value;
            out_beat.status      <= res_status;
            m_tvalid             <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = out_beat;

endmodule

// File: hw/rtl/clt_checker.sv
// Port-level checks for the compacting list table, bound to the top level.
// Depends on clt_pkg and compacting_list_table_core.
module clt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [clt_pkg::IN_W-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [clt_pkg::OUT_W-1:0] m_tdata
);

  clt_pkg::out_beat_t obeat;
  assign obeat = m_tdata;

  // no result pending right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // one item in flight: input closes after each accepted beat
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // only a successful operation returns a nonzero word
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (obeat.status != clt_pkg::ST_DONE) |-> obeat.read_value == '0)
    else $error("read value nonzero on failed operation");

  // pad bits stay zero, status is known, and input data is known when valid
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid |-> obeat.pad == '0 && !$isunknown(obeat.status)) and
    (s_tvalid |-> !$isunknown(s_tdata)))
    else $error("output pad or status corrupt, or input data unknown");

endmodule

bind compacting_list_table_core clt_checker u_clt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/compacting_list_table_core_tb.sv
// Self-checking testbench for compacting_list_table_core: directed and random
// append/delete/get traffic with random idling on both stream sides.
// Depends on clt_pkg and the RTL of compacting_list_table_core.
module compacting_list_table_core_tb;

  localparam int unsigned CAPACITY = 64;
  localparam logic [clt_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 80;

  // Expected-result store with its own copy of the list contents
  class list_table_scoreboard;
    logic [clt_pkg::WORD_W-1:0] words [CAPACITY];
    int unsigned used_count;
    clt_pkg::out_beat_t pending_results [$];
    int unsigned mismatches;

    function new();
      used_count = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted request to the list and queue its result
    function void note_request(clt_pkg::in_beat_t req);
      clt_pkg::out_beat_t exp_beat;
      exp_beat = '0;
      exp_beat.status = clt_pkg::ST_RANGE;
      case (req.op)
        clt_pkg::OP_APPEND: begin
          if (used_count >= CAPACITY) begin
            exp_beat.status = clt_pkg::ST_FULL;
          end else begin
            words[used_count] = req.value;
            used_count++;
            exp_beat.status = clt_pkg::ST_DONE;
          end
        end
        clt_pkg::OP_DELETE: begin
          if (req.index < used_count) begin
            for (int unsigned i = req.index; i + 1 < used_count; i++)
              words[i] = words[i + 1];
            used_count--;
            exp_beat.status = clt_pkg::ST_DONE;
          end
        end
        clt_pkg::OP_GET: begin
          if (req.index < used_count) begin
            exp_beat.read_value = words[req.index];
            exp_beat.status = clt_pkg::ST_DONE;
          end
        end
        default: exp_beat.status = clt_pkg::ST_RANGE;
      endcase
      exp_beat.entry_count = used_count[clt_pkg::COUNT_W-1:0];
      pending_results.push_back(exp_beat);
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_result(clt_pkg::out_beat_t got);
      clt_pkg::out_beat_t exp_beat;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d read_value %h entry_count %0d",
               got.status, got.read_value, got.entry_count);
        mismatches++;
        return;
      end
      exp_beat = pending_results.pop_front();
      if (got.status !== exp_beat.status) begin
        $error("status: expected %0d, got %0d", exp_beat.status, got.status);
        mismatches++;
      end
      if (got.read_value !== exp_beat.read_value) begin
        $error("read_value: expected %h, got %h", exp_beat.read_value, got.read_value);
        mismatches++;
      end
      if (got.entry_count !== exp_beat.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp_beat.entry_count,
               got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [clt_pkg::IN_W-1:0]  s_tdata = '0;   // op, index, value
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [clt_pkg::OUT_W-1:0] m_tdata;        // status, read_value, entry_count, pad

  list_table_scoreboard sb = new();
  int unsigned send_idle_pct = 25;
  int unsigned recv_stall_pct = 79;
  int unsigned sent_count = 0;

  compacting_list_table_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random backpressure and checking of every taken beat
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(clt_pkg::out_beat_t'(m_tdata));
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any beat moving
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Drive one request beat, with a random gap ahead of it
  task automatic send_request(input logic [clt_pkg::OP_W-1:0] op,
                              input logic [clt_pkg::INDEX_W-1:0] index,
                              input logic [clt_pkg::WORD_W-1:0] value);
    clt_pkg::in_beat_t req;
    int unsigned gap;
    req.op = op;
    req.index = index;
    req.value = value;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= req;
    do @(posedge clk); while (!s_tready);
    sb.note_request(req);
    sent_count++;
  endtask

  function automatic logic [clt_pkg::WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly indices inside the list, sometimes anywhere in the field
  function automatic logic [clt_pkg::INDEX_W-1:0] pick_index();
    if (sb.used_count > 0 && $urandom_range(99) < 85)
      return clt_pkg::INDEX_W'($urandom_range(sb.used_count - 1));
    return clt_pkg::INDEX_W'($urandom_range(63));
  endfunction

  // Idling scheme follows progress through the random part
  task automatic update_idling();
    if (sent_count < RANDOM_ITEMS / 3) begin
      send_idle_pct = 25;
      recv_stall_pct = 79;
    end else if (sent_count < 2 * RANDOM_ITEMS / 3) begin
      send_idle_pct = 79;
      recv_stall_pct = 25;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  task automatic send_mixed();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35)
      send_request(clt_pkg::OP_APPEND, clt_pkg::INDEX_W'($urandom_range(63)), rand_word());
    else if (pick < 60) send_request(clt_pkg::OP_DELETE, pick_index(), rand_word());
    else if (pick < 92) send_request(clt_pkg::OP_GET, pick_index(), rand_word());
    else send_request(OP_UNKNOWN, clt_pkg::INDEX_W'($urandom_range(63)), rand_word());
  endtask

  initial begin
    int unsigned mode;
    int unsigned extra;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, word extremes, bounds of index, unknown op
    send_request(clt_pkg::OP_GET, 6'd0, '0);
    send_request(clt_pkg::OP_DELETE, 6'd0, '1);
    send_request(OP_UNKNOWN, 6'd63, '1);
    send_request(clt_pkg::OP_APPEND, 6'd0, 64'h0);
    send_request(clt_pkg::OP_APPEND, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(clt_pkg::OP_APPEND, 6'd21, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(clt_pkg::OP_APPEND, 6'd42, 64'h5555_5555_5555_5555);
    send_request(clt_pkg::OP_GET, 6'd0, '1);
    send_request(clt_pkg::OP_GET, 6'd1, '0);
    send_request(clt_pkg::OP_GET, 6'd3, '0);
    send_request(clt_pkg::OP_GET, 6'd4, '0);
    send_request(clt_pkg::OP_GET, 6'd63, '0);
    send_request(clt_pkg::OP_DELETE, 6'd4, '0);
    send_request(clt_pkg::OP_DELETE, 6'd3, '0);
    send_request(clt_pkg::OP_DELETE, 6'd0, '0);
    send_request(clt_pkg::OP_GET, 6'd0, '0);
    send_request(clt_pkg::OP_APPEND, 6'd0, 64'h8000_0000_0000_0001);
    send_request(clt_pkg::OP_DELETE, 6'd1, '0);
    send_request(OP_UNKNOWN, 6'd0, '0);
    send_request(clt_pkg::OP_GET, 6'd1, '0);
    send_request(clt_pkg::OP_GET, 6'd2, '0);
    sent_count = 0;

    // Random: fill to full, drain to empty, and mixed bursts
    while (sent_count < RANDOM_ITEMS) begin
      update_idling();
      mode = $urandom_range(9);
      if (mode < 3) begin
        extra = $urandom_range(3, 1);
        while (sb.used_count < CAPACITY)
          send_request(clt_pkg::OP_APPEND, clt_pkg::INDEX_W'($urandom_range(63)),
                       rand_word());
        repeat (extra)
          send_request(clt_pkg::OP_APPEND, clt_pkg::INDEX_W'($urandom_range(63)),
                       rand_word());
      end else if (mode < 5) begin
        extra = $urandom_range(2, 1);
        while (sb.used_count > 0) begin
          if ($urandom_range(3) == 0) send_request(clt_pkg::OP_GET, pick_index(), rand_word());
          else send_request(clt_pkg::OP_DELETE, pick_index(), rand_word());
        end
        repeat (extra) send_mixed();
      end else begin
        repeat (20) send_mixed();
      end
    end
    s_tvalid <= 1'b0;

    // Wait out the remaining results, then the longest delete shift
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
